// ----- rtl/core/adaptive_step_size_controller_core_macros.svh -----
// ----------------------------------------------------------------------------
// adaptive step size controller core - assertion macros
// shared checking macros for the core rtl
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_STEP_SIZE_CONTROLLER_CORE_MACROS_SVH
`define ADAPTIVE_STEP_SIZE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication under reset
`define ASC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define ASC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/asc_pkg.sv -----
// ----------------------------------------------------------------------------
// asc_pkg
// types, constants and helper functions of the step size controller
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int TICK_BITS       = 16;
    localparam int STEP_BITS       = 24;
    localparam int TICK_POS_BITS   = 32;
    localparam int CFG_TPS_BITS    = 16;
    localparam int CFG_STRIDE_BITS = 16;
    localparam int CFG_TOTAL_BITS  = 24;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 24;
    localparam int KOF_BITS        = 3;

    // widths for the substep size arithmetic
    localparam int WIDE_BITS = (TICK_BITS + 1 > CFG_TPS_BITS + 1) ? TICK_BITS + 1
                                                                   : CFG_TPS_BITS + 1;
    localparam int SUM_BITS  = WIDE_BITS + 1;
    localparam int CMP_BITS  = (STEP_BITS > CFG_TOTAL_BITS) ? STEP_BITS : CFG_TOTAL_BITS;

    localparam logic [CFG_TPS_BITS-1:0]    TPS_RESET    = CFG_TPS_BITS'(128);
    localparam logic [CFG_STRIDE_BITS-1:0] STRIDE_RESET = CFG_STRIDE_BITS'(1);
    localparam logic [CFG_TOTAL_BITS-1:0]  TOTAL_RESET  = CFG_TOTAL_BITS'(10);
    localparam logic [TICK_BITS-1:0]       SUB_RESET    = TICK_BITS'(128);
    localparam logic [TICK_BITS-1:0]       SUB_ONE      = TICK_BITS'(1);
    localparam logic [STEP_BITS-1:0]       STEP_MAX     = '1;
    localparam logic [KOF_BITS-1:0]        KOF_ABORT    = KOF_BITS'(2);
    localparam logic [KOF_BITS-1:0]        KOF_MAX      = '1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_TICKS_PER_STEP = 2'd0,
        CFG_SAMPLE_STRIDE  = 2'd1,
        CFG_TOTAL_STEPS    = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        OC_ADVANCE        = 3'd0,
        OC_RECOVERED      = 3'd1,
        OC_HALVE_RETRY    = 3'd2,
        OC_LAST_TRY       = 3'd3,
        OC_ABORT          = 3'd4,
        OC_FROZEN_ADVANCE = 3'd5,
        OC_NO_CHANGE      = 3'd6
    } outcome_t;

    typedef struct packed {
        logic step_ok;
        logic fail_kind_one;
        logic abort_request;
    } item_t;

    typedef struct packed {
        logic [CFG_TPS_BITS-1:0]    ticks_per_step;
        logic [CFG_STRIDE_BITS-1:0] sample_stride;
        logic [CFG_TOTAL_BITS-1:0]  total_steps;
    } cfg_t;

    typedef struct packed {
        logic [TICK_POS_BITS-1:0]   tick_count;
        logic [CFG_TPS_BITS-1:0]    grid_phase;
        logic [TICK_BITS-1:0]       substep;
        logic [TICK_BITS-1:0]       last_tried;
        logic [STEP_BITS-1:0]       step_count;
        logic [CFG_STRIDE_BITS-1:0] sample_phase;
        logic [STEP_BITS-1:0]       sample_count;
        logic [KOF_BITS-1:0]        kind_one_fails;
        logic                       last_try_flag;
        logic                       frozen_flag;
        logic [TICK_BITS-1:0]       saved_substep;
        logic                       done_flag;
    } state_t;

    typedef struct packed {
        outcome_t                 outcome;
        logic [STEP_BITS-1:0]     full_steps_done;
        logic [TICK_POS_BITS-1:0] tick_position;
        logic [TICK_BITS-1:0]     next_substep;
        logic                     at_sample_point;
        logic                     frozen_next;
        logic [STEP_BITS-1:0]     sample_index;
        logic                     finished;
    } result_t;

    // grid phase plus substep, reduced once by the grid size, cleared if still out of range
    function automatic logic [CFG_TPS_BITS-1:0] grid_wrap(
        input logic [CFG_TPS_BITS-1:0] phase,
        input logic [TICK_BITS-1:0]    add,
        input logic [CFG_TPS_BITS-1:0] modulus
    );
        logic [SUM_BITS-1:0] s;
        s = SUM_BITS'(phase) + SUM_BITS'(add);
        if (s >= SUM_BITS'(modulus))
        begin
            s = s - SUM_BITS'(modulus);
        end
        if (s >= SUM_BITS'(modulus))
        begin
            s = '0;
        end
        return s[CFG_TPS_BITS-1:0];
    endfunction

    // sample phase plus one, reduced once by the stride, cleared if still out of range
    function automatic logic [CFG_STRIDE_BITS-1:0] stride_wrap(
        input logic [CFG_STRIDE_BITS-1:0] phase,
        input logic [CFG_STRIDE_BITS-1:0] modulus
    );
        logic [CFG_STRIDE_BITS:0] s;
        s = {1'b0, phase} + (CFG_STRIDE_BITS + 1)'(1);
        if (s >= {1'b0, modulus})
        begin
            s = s - {1'b0, modulus};
        end
        if (s >= {1'b0, modulus})
        begin
            s = '0;
        end
        return s[CFG_STRIDE_BITS-1:0];
    endfunction

    function automatic logic step_gt(
        input logic [STEP_BITS-1:0]      step,
        input logic [CFG_TOTAL_BITS-1:0] total
    );
        return CMP_BITS'(step) > CMP_BITS'(total);
    endfunction

    function automatic logic step_eq(
        input logic [STEP_BITS-1:0]      step,
        input logic [CFG_TOTAL_BITS-1:0] total
    );
        return CMP_BITS'(step) == CMP_BITS'(total);
    endfunction

endpackage

// ----- rtl/core/adaptive_step_size_controller_core.sv -----
// ----------------------------------------------------------------------------
// adaptive_step_size_controller_core
// integer substep controller for an adaptive time integrator
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one attempt outcome per word:
//   step_ok, fail_kind_one, abort_request
//   output channel (out_valid / out_stall) returns exactly one result word per
//   input word: outcome code, position, next substep and status flags
//   config channel (cfg_valid / cfg_ready) writes ticks_per_step (index 0),
//   sample_stride (index 1) and total_steps (index 2); cfg_ready is always
//   high, write only while no word is in flight
//   path: input register, then the state update lands in the result register
//   once that register can take the word
//   throughput: one word per cycle without out_stall, set by the state update loop
//   receiver stall: the result register holds its word; the input register
//   keeps one more word, after which in_stall rises
//   reset: all state cleared, substep and last tried size set to 128 ticks,
//   registers back to 128 / 1 / 10, both channels empty
// ----------------------------------------------------------------------------
`include "adaptive_step_size_controller_core_macros.svh"

module adaptive_step_size_controller_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // attempt outcome channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 step_ok,
    input  logic                                 fail_kind_one,
    input  logic                                 abort_request,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [2:0]                           outcome,
    output logic [asc_pkg::STEP_BITS-1:0]        full_steps_done,
    output logic [asc_pkg::TICK_POS_BITS-1:0]    tick_position,
    output logic [asc_pkg::TICK_BITS-1:0]        next_substep,
    output logic                                 at_sample_point,
    output logic                                 frozen_next,
    output logic [asc_pkg::STEP_BITS-1:0]        sample_index,
    output logic                                 finished,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [asc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [asc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    asc_pkg::item_t   in_item;
    asc_pkg::item_t   hold_item;
    logic             hold_valid;
    logic             can_load;
    logic             fire;
    asc_pkg::cfg_t    cfg_reg;
    asc_pkg::cfg_t    cfg_next;
    asc_pkg::state_t  state_reg;
    asc_pkg::state_t  state_next;
    asc_pkg::state_t  upd_state;
    asc_pkg::result_t upd_result;
    asc_pkg::result_t out_data;

    assign in_item.step_ok       = step_ok;
    assign in_item.fail_kind_one = fail_kind_one;
    assign in_item.abort_request = abort_request;

    // held word goes through the update whenever the result register can take it
    assign fire      = hold_valid && can_load;
    assign cfg_ready = 1'b1;

    asc_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .fire       (fire),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    asc_update u_update
    (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (hold_item),
        .nxt  (upd_state),
        .res  (upd_result)
    );

    asc_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .load_data (upd_result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // configuration register decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                asc_pkg::CFG_TICKS_PER_STEP:
                begin
                    cfg_next.ticks_per_step = cfg_data[asc_pkg::CFG_TPS_BITS-1:0];
                end
                asc_pkg::CFG_SAMPLE_STRIDE:
                begin
                    cfg_next.sample_stride = cfg_data[asc_pkg::CFG_STRIDE_BITS-1:0];
                end
                asc_pkg::CFG_TOTAL_STEPS:
                begin
                    cfg_next.total_steps = cfg_data[asc_pkg::CFG_TOTAL_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // controller state only moves when a word is processed
    assign state_next = fire ? upd_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_step   <= asc_pkg::TPS_RESET;
            cfg_reg.sample_stride    <= asc_pkg::STRIDE_RESET;
            cfg_reg.total_steps      <= asc_pkg::TOTAL_RESET;
            state_reg.tick_count     <= '0;
            state_reg.grid_phase     <= '0;
            state_reg.substep        <= asc_pkg::SUB_RESET;
            state_reg.last_tried     <= asc_pkg::SUB_RESET;
            state_reg.step_count     <= '0;
            state_reg.sample_phase   <= '0;
            state_reg.sample_count   <= '0;
            state_reg.kind_one_fails <= '0;
            state_reg.last_try_flag  <= 1'b0;
            state_reg.frozen_flag    <= 1'b0;
            state_reg.saved_substep  <= '0;
            state_reg.done_flag      <= 1'b0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            state_reg <= state_next;
        end
    end

    assign outcome         = out_data.outcome;
    assign full_steps_done = out_data.full_steps_done;
    assign tick_position   = out_data.tick_position;
    assign next_substep    = out_data.next_substep;
    assign at_sample_point = out_data.at_sample_point;
    assign frozen_next     = out_data.frozen_next;
    assign sample_index    = out_data.sample_index;
    assign finished        = out_data.finished;

    // a finished run stays finished
    `ASC_ASSERT_NEXT(a_done_sticky, clk, rst_n, state_reg.done_flag, state_reg.done_flag,
        "finished run left the done state")

    // state is untouched unless a word goes through the update
    `ASC_ASSERT_NEXT(a_state_hold, clk, rst_n, !fire, $stable(state_reg),
        "controller state changed without a processed word")

    // a held word that cannot move is kept
    `ASC_ASSERT_NEXT(a_hold_kept, clk, rst_n, hold_valid && !fire, hold_valid,
        "held input word lost")

    // every processed word shows up on the result channel
    `ASC_ASSERT_NEXT(a_fire_result, clk, rst_n, fire, out_valid,
        "processed word produced no result")

    // kind-one counter never passes two bumps past the abort level
    `ASC_ASSERT_NOW(a_kof_range, clk, rst_n, 1'b1,
        state_reg.kind_one_fails <= asc_pkg::KOF_BITS'(4),
        "kind-one fail counter out of range")

endmodule

// ----- rtl/core/asc_in_reg.sv -----
// ----------------------------------------------------------------------------
// asc_in_reg
// input register holding one attempt outcome until the update stage takes it
// ----------------------------------------------------------------------------
module asc_in_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  asc_pkg::item_t in_item,
    input  logic           fire,
    output logic           hold_valid,
    output asc_pkg::item_t hold_item
);

    logic           valid_reg;
    logic           valid_next;
    asc_pkg::item_t item_reg;
    logic           accept;

    assign in_stall   = valid_reg && !fire;
    assign accept     = in_valid && !in_stall;
    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- rtl/core/asc_update.sv -----
// ----------------------------------------------------------------------------
// asc_update
// classifies one attempt and computes the next controller state and result
// ----------------------------------------------------------------------------
module asc_update
(
    input  asc_pkg::cfg_t    cfg,
    input  asc_pkg::state_t  cur,
    input  asc_pkg::item_t   item,
    output asc_pkg::state_t  nxt,
    output asc_pkg::result_t res
);

    asc_pkg::outcome_t                      oc;
    logic [asc_pkg::CFG_TPS_BITS-1:0]       tps_eff;
    logic [asc_pkg::CFG_STRIDE_BITS-1:0]    stride_eff;
    logic                                   full;
    logic                                   last_try;
    logic [asc_pkg::CFG_STRIDE_BITS-1:0]    sp;
    logic [asc_pkg::CFG_TPS_BITS-1:0]       gp;
    logic [asc_pkg::TICK_POS_BITS:0]        tick_sum;
    logic [asc_pkg::WIDE_BITS-1:0]          ext;
    logic [asc_pkg::WIDE_BITS-1:0]          rem;
    logic [asc_pkg::WIDE_BITS-1:0]          lim;

    assign tps_eff    = (cfg.ticks_per_step == '0) ? asc_pkg::CFG_TPS_BITS'(1)
                                                   : cfg.ticks_per_step;
    assign stride_eff = (cfg.sample_stride == '0) ? asc_pkg::CFG_STRIDE_BITS'(1)
                                                  : cfg.sample_stride;

    always_comb
    begin
        nxt      = cur;
        oc       = asc_pkg::OC_NO_CHANGE;
        full     = 1'b0;
        last_try = 1'b0;
        sp       = '0;
        gp       = '0;
        tick_sum = '0;
        ext      = '0;
        rem      = '0;
        lim      = '0;

        if (!cur.done_flag && asc_pkg::step_gt(cur.step_count, cfg.total_steps))
        begin
            // count already past the end: finish and restore the substep
            nxt.done_flag = 1'b1;
            nxt.substep   = cur.saved_substep;
        end
        else if (!cur.done_flag)
        begin
            full = (asc_pkg::grid_wrap(cur.grid_phase, cur.substep, tps_eff) == '0);

            // final step runs with a zero substep
            if (asc_pkg::step_eq(cur.step_count, cfg.total_steps))
            begin
                nxt.saved_substep = cur.substep;
                nxt.substep       = '0;
                nxt.frozen_flag   = 1'b1;
            end

            if (item.step_ok)
            begin
                oc = cur.last_try_flag ? asc_pkg::OC_RECOVERED : asc_pkg::OC_ADVANCE;
            end
            else if (cur.last_try_flag)
            begin
                oc = asc_pkg::OC_ABORT;
            end
            else if (nxt.substep > asc_pkg::SUB_ONE)
            begin
                oc = asc_pkg::OC_HALVE_RETRY;
            end
            else if (nxt.substep == asc_pkg::SUB_ONE)
            begin
                oc = asc_pkg::OC_LAST_TRY;
            end

            if (!item.step_ok && item.fail_kind_one)
            begin
                if (cur.kind_one_fails >= asc_pkg::KOF_ABORT)
                begin
                    oc = asc_pkg::OC_ABORT;
                end
                else
                begin
                    nxt.kind_one_fails = cur.kind_one_fails + asc_pkg::KOF_BITS'(1);
                end
            end
            if (!item.fail_kind_one)
            begin
                nxt.kind_one_fails = '0;
            end

            if (nxt.frozen_flag)
            begin
                oc = asc_pkg::OC_FROZEN_ADVANCE;
            end
            else if (item.abort_request)
            begin
                oc = asc_pkg::OC_ABORT;
            end

            case (oc) inside
                asc_pkg::OC_ABORT:
                begin
                    nxt.frozen_flag = 1'b1;
                    nxt.done_flag   = 1'b1;
                end
                asc_pkg::OC_ADVANCE, asc_pkg::OC_RECOVERED, asc_pkg::OC_FROZEN_ADVANCE:
                begin
                    nxt.last_try_flag = 1'b0;
                    if (full && cur.step_count != asc_pkg::STEP_MAX)
                    begin
                        nxt.step_count   = cur.step_count + asc_pkg::STEP_BITS'(1);
                        sp               = asc_pkg::stride_wrap(cur.sample_phase, stride_eff);
                        nxt.sample_phase = sp;
                        if (sp == '0 && cur.sample_count != asc_pkg::STEP_MAX)
                        begin
                            nxt.sample_count = cur.sample_count + asc_pkg::STEP_BITS'(1);
                        end
                    end
                    // saturating tick position
                    tick_sum = {1'b0, cur.tick_count}
                             + (asc_pkg::TICK_POS_BITS + 1)'(nxt.substep);
                    nxt.tick_count = tick_sum[asc_pkg::TICK_POS_BITS] ? '1
                                   : tick_sum[asc_pkg::TICK_POS_BITS-1:0];
                    gp = asc_pkg::grid_wrap(cur.grid_phase, nxt.substep, tps_eff);
                    nxt.grid_phase = gp;
                    // grow by doubling, capped by grid size and ticks to next grid point
                    ext = full ? asc_pkg::WIDE_BITS'({cur.last_tried, 1'b0})
                               : asc_pkg::WIDE_BITS'({nxt.substep, 1'b0});
                    rem = asc_pkg::WIDE_BITS'(tps_eff) - asc_pkg::WIDE_BITS'(gp);
                    lim = asc_pkg::WIDE_BITS'(tps_eff);
                    if (ext < lim)
                    begin
                        lim = ext;
                    end
                    if (rem < lim)
                    begin
                        lim = rem;
                    end
                    nxt.last_tried = nxt.substep;
                    nxt.substep    = lim[asc_pkg::TICK_BITS-1:0];
                end
                asc_pkg::OC_HALVE_RETRY, asc_pkg::OC_LAST_TRY:
                begin
                    // kind-one counter gets its second bump here
                    if (item.fail_kind_one)
                    begin
                        if (nxt.kind_one_fails != asc_pkg::KOF_MAX)
                        begin
                            nxt.kind_one_fails = nxt.kind_one_fails + asc_pkg::KOF_BITS'(1);
                        end
                    end
                    else
                    begin
                        nxt.kind_one_fails = '0;
                    end
                    last_try          = (nxt.substep == asc_pkg::SUB_ONE);
                    nxt.last_try_flag = last_try;
                    nxt.last_tried    = nxt.substep;
                    if (!last_try && !item.fail_kind_one)
                    begin
                        nxt.substep = nxt.substep >> 1;
                    end
                end
                default:
                begin
                end
            endcase

            if (!nxt.done_flag && asc_pkg::step_gt(nxt.step_count, cfg.total_steps))
            begin
                nxt.done_flag = 1'b1;
                nxt.substep   = nxt.saved_substep;
            end
        end
    end

    always_comb
    begin
        res.outcome         = oc;
        res.full_steps_done = nxt.step_count;
        res.tick_position   = nxt.tick_count;
        res.next_substep    = nxt.substep;
        res.at_sample_point = (nxt.grid_phase == '0 && nxt.sample_phase == '0)
                           || asc_pkg::step_eq(nxt.step_count, cfg.total_steps);
        res.frozen_next     = !nxt.done_flag
                           && asc_pkg::step_eq(nxt.step_count, cfg.total_steps);
        res.sample_index    = nxt.sample_count;
        res.finished        = nxt.done_flag;
    end

endmodule

// ----- rtl/core/asc_out_reg.sv -----
// ----------------------------------------------------------------------------
// asc_out_reg
// result register, holds a word until the receiver takes it
// ----------------------------------------------------------------------------
module asc_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  asc_pkg::result_t load_data,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_stall,
    output asc_pkg::result_t out_data
);

    logic             valid_reg;
    logic             valid_next;
    asc_pkg::result_t data_reg;

    assign can_load  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ----- bench/asc_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// asc_tb_pkg
// expected-result tracking for the step size controller bench
// ----------------------------------------------------------------------------
package asc_tb_pkg;

    import asc_pkg::*;

    class step_ctrl_scoreboard;

        // register copy
        logic [CFG_TPS_BITS-1:0]    cfg_tps;
        logic [CFG_STRIDE_BITS-1:0] cfg_stride;
        logic [CFG_TOTAL_BITS-1:0]  cfg_total;

        // controller state copy
        state_t st;

        result_t     expected_reports[$];
        int unsigned mismatches;

        function new();
            cfg_tps    = TPS_RESET;
            cfg_stride = STRIDE_RESET;
            cfg_total  = TOTAL_RESET;
            st            = '0;
            st.substep    = SUB_RESET;
            st.last_tried = SUB_RESET;
            mismatches    = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_TICKS_PER_STEP: cfg_tps    = data[CFG_TPS_BITS-1:0];
                CFG_SAMPLE_STRIDE:  cfg_stride = data[CFG_STRIDE_BITS-1:0];
                CFG_TOTAL_STEPS:    cfg_total  = data[CFG_TOTAL_BITS-1:0];
                default: ;
            endcase
        endfunction

        // phase plus step, folded back once, cleared if still out of range
        function logic [31:0] phase_step(logic [31:0] phase, logic [31:0] add,
                                         logic [31:0] modulus);
            logic [33:0] s;
            s = 34'(phase) + 34'(add);
            if (s >= 34'(modulus))
            begin
                s = s - 34'(modulus);
            end
            if (s >= 34'(modulus))
            begin
                s = '0;
            end
            return s[31:0];
        endfunction

        // advance the state copy by one attempt and queue the result word
        function void note_attempt(logic ok, logic k1, logic ab);
            logic [16:0] grid;
            logic [16:0] stride;
            logic        full;
            logic [17:0] ext;
            logic [16:0] rem;
            logic [17:0] pick;
            logic [32:0] tsum;
            outcome_t    oc;
            result_t     r;
            grid   = (cfg_tps == 0) ? 17'd1 : 17'(cfg_tps);
            stride = (cfg_stride == 0) ? 17'd1 : 17'(cfg_stride);
            oc     = OC_NO_CHANGE;
            if (!st.done_flag && st.step_count > cfg_total)
            begin
                st.done_flag = 1'b1;
                st.substep   = st.saved_substep;
            end
            else if (!st.done_flag)
            begin
                full = (phase_step(32'(st.grid_phase), 32'(st.substep), 32'(grid)) == '0);
                if (st.step_count == cfg_total)
                begin
                    st.saved_substep = st.substep;
                    st.substep       = '0;
                    st.frozen_flag   = 1'b1;
                end
                if (ok)
                    oc = st.last_try_flag ? OC_RECOVERED : OC_ADVANCE;
                else if (st.last_try_flag)
                    oc = OC_ABORT;
                else if (st.substep > SUB_ONE)
                    oc = OC_HALVE_RETRY;
                else if (st.substep == SUB_ONE)
                    oc = OC_LAST_TRY;
                if (!ok && k1)
                begin
                    if (st.kind_one_fails >= KOF_ABORT)
                        oc = OC_ABORT;
                    else
                        st.kind_one_fails = st.kind_one_fails + KOF_BITS'(1);
                end
                if (!k1)
                    st.kind_one_fails = '0;
                if (st.frozen_flag)
                    oc = OC_FROZEN_ADVANCE;
                else if (ab)
                    oc = OC_ABORT;

                case (oc)
                    OC_ABORT:
                    begin
                        st.frozen_flag = 1'b1;
                        st.done_flag   = 1'b1;
                    end
                    OC_ADVANCE, OC_RECOVERED, OC_FROZEN_ADVANCE:
                    begin
                        st.last_try_flag = 1'b0;
                        if (full && st.step_count != STEP_MAX)
                        begin
                            st.step_count   = st.step_count + STEP_BITS'(1);
                            st.sample_phase = CFG_STRIDE_BITS'(phase_step(
                                32'(st.sample_phase), 32'd1, 32'(stride)));
                            if (st.sample_phase == '0 && st.sample_count != STEP_MAX)
                                st.sample_count = st.sample_count + STEP_BITS'(1);
                        end
                        tsum = 33'(st.tick_count) + 33'(st.substep);
                        st.tick_count = tsum[32] ? '1 : tsum[31:0];
                        st.grid_phase = CFG_TPS_BITS'(phase_step(
                            32'(st.grid_phase), 32'(st.substep), 32'(grid)));
                        ext  = full ? (18'(st.last_tried) << 1) : (18'(st.substep) << 1);
                        rem  = grid - 17'(st.grid_phase);
                        pick = 18'(grid);
                        if (ext < pick)
                            pick = ext;
                        if (18'(rem) < pick)
                            pick = 18'(rem);
                        st.last_tried = st.substep;
                        st.substep    = pick[TICK_BITS-1:0];
                    end
                    OC_HALVE_RETRY, OC_LAST_TRY:
                    begin
                        if (k1)
                        begin
                            if (st.kind_one_fails != KOF_MAX)
                                st.kind_one_fails = st.kind_one_fails + KOF_BITS'(1);
                        end
                        else
                            st.kind_one_fails = '0;
                        st.last_try_flag = (st.substep == SUB_ONE);
                        st.last_tried    = st.substep;
                        if (!st.last_try_flag && !k1)
                            st.substep = st.substep >> 1;
                    end
                    default: ;
                endcase

                if (!st.done_flag && st.step_count > cfg_total)
                begin
                    st.done_flag = 1'b1;
                    st.substep   = st.saved_substep;
                end
            end

            r.outcome         = oc;
            r.full_steps_done = st.step_count;
            r.tick_position   = st.tick_count;
            r.next_substep    = st.substep;
            r.at_sample_point = (st.grid_phase == '0 && st.sample_phase == '0)
                                || st.step_count == cfg_total;
            r.frozen_next     = !st.done_flag && st.step_count == cfg_total;
            r.sample_index    = st.sample_count;
            r.finished        = st.done_flag;
            expected_reports  = {expected_reports, r};
        endfunction

        function string describe(result_t r);
            return $sformatf({"outcome %0d steps %0d ticks %0d substep %0d",
                              " sample %0b frozen %0b index %0d finished %0b"},
                             r.outcome, r.full_steps_done, r.tick_position,
                             r.next_substep, r.at_sample_point, r.frozen_next,
                             r.sample_index, r.finished);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("tb_top: mismatch %0d: %s", mismatches, what);
        endfunction

        function void check_result(result_t got);
            result_t want;
            logic    same;
            if (expected_reports.size() == 0)
            begin
                flag({"word with nothing expected: ", describe(got)});
            end
            else
            begin
                want = expected_reports.pop_front();
                same = (got.outcome === want.outcome)
                    && (got.full_steps_done === want.full_steps_done)
                    && (got.tick_position === want.tick_position)
                    && (got.next_substep === want.next_substep)
                    && (got.at_sample_point === want.at_sample_point)
                    && (got.frozen_next === want.frozen_next)
                    && (got.sample_index === want.sample_index)
                    && (got.finished === want.finished);
                if (!same)
                    flag({"expected ", describe(want), " | got ", describe(got)});
            end
        endfunction

    endclass

endpackage

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the adaptive step size controller core: attempt
// outcomes go in one word at a time, every result word is compared against a
// state-tracking predictor, under random idling on both channels and a run of
// register settings; the run ends on one randomly chosen terminal path
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import asc_pkg::*;
    import asc_tb_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 7;
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 190;
    localparam int LONG_HOLD_AT     = 400;   // result count that triggers the long hold
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = 6;     // settle time after the last expected word
    localparam int WATCHDOG_NS      = 5_000_000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // attempt channel
    logic in_valid      = 1'b0;
    logic in_stall;
    logic step_ok       = 1'b0;
    logic fail_kind_one = 1'b0;
    logic abort_request = 1'b0;

    // result channel
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [2:0]               outcome;
    logic [STEP_BITS-1:0]     full_steps_done;
    logic [TICK_POS_BITS-1:0] tick_position;
    logic [TICK_BITS-1:0]     next_substep;
    logic                     at_sample_point;
    logic                     frozen_next;
    logic [STEP_BITS-1:0]     sample_index;
    logic                     finished;

    // register write channel
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    step_ctrl_scoreboard board;

    // per-phase knobs for sender and receiver
    bit          calm     = 1'b0;   // no idling on either side
    int unsigned fail_pct = 20;     // share of failed attempts in random words
    int unsigned results_seen = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    adaptive_step_size_controller_core dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .step_ok         (step_ok),
        .fail_kind_one   (fail_kind_one),
        .abort_request   (abort_request),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .outcome         (outcome),
        .full_steps_done (full_steps_done),
        .tick_position   (tick_position),
        .next_substep    (next_substep),
        .at_sample_point (at_sample_point),
        .frozen_next     (frozen_next),
        .sample_index    (sample_index),
        .finished        (finished),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // idle length for one word, random, or zero when the phase runs calm
    function automatic int unsigned pause_len();
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    // offer one attempt word and wait for it to be taken; the predictor is
    // advanced right at the accepting edge so the next word can look at it
    task automatic send_attempt(input logic ok, input logic k1, input logic ab);
        int unsigned gap;
        gap = pause_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        step_ok       <= ok;
        fail_kind_one <= k1;
        abort_request <= ab;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_attempt(ok, k1, ab);
    endtask

    // random attempt that keeps the run alive
    task automatic send_random_attempt();
        logic ok;
        logic k1;
        ok = ($urandom_range(0, 99) >= fail_pct);
        k1 = ($urandom_range(0, 3) == 0);
        // a failure right after a last try would abort
        if (!ok && board.st.last_try_flag)
            ok = 1'b1;
        // a second kind-one failure in a row would abort
        if (!ok && k1 && board.st.kind_one_fails >= KOF_ABORT)
            k1 = 1'b0;
        send_attempt(ok, k1, 1'b0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_register(idx, data);
    endtask

    task automatic program_regs(input logic [CFG_TPS_BITS-1:0]    tps,
                                input logic [CFG_STRIDE_BITS-1:0] stride,
                                input logic [CFG_TOTAL_BITS-1:0]  total);
        write_reg(CFG_TICKS_PER_STEP, CFG_DATA_BITS'(tps));
        write_reg(CFG_SAMPLE_STRIDE, CFG_DATA_BITS'(stride));
        write_reg(CFG_TOTAL_STEPS, CFG_DATA_BITS'(total));
        cfg_valid <= 1'b0;
    endtask

    // stop offering, let every expected word come back, then let the bench settle
    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall per word, one long hold to back the block up
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned hold;
        bit          long_hold_done;
        result_t     got;
        long_hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!long_hold_done && results_seen >= LONG_HOLD_AT)
            begin
                // sender keeps offering meanwhile, so in_stall has to rise
                hold           = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            else
                hold = pause_len();
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got.outcome         = outcome_t'(outcome);
            got.full_steps_done = full_steps_done;
            got.tick_position   = tick_position;
            got.next_substep    = next_substep;
            got.at_sample_point = at_sample_point;
            got.frozen_next     = frozen_next;
            got.sample_index    = sample_index;
            got.finished        = finished;
            board.check_result(got);
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus: directed opening, random phases, one terminal path, then
    // words after the finish
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int                         phase;
        int unsigned                end_kind;
        int                         i;
        logic [CFG_TPS_BITS-1:0]    tps;
        logic [CFG_STRIDE_BITS-1:0] stride;
        logic [CFG_TOTAL_BITS-1:0]  total;
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening under reset settings: grid 128, stride 1, ten steps
        send_attempt(1'b1, 1'b0, 1'b0);       // full step at reset substep
        send_attempt(1'b0, 1'b0, 1'b0);       // plain failure halves
        send_attempt(1'b1, 1'b0, 1'b0);       // half step, off the grid
        send_attempt(1'b1, 1'b0, 1'b0);       // lands on the grid, grows back
        send_attempt(1'b0, 1'b1, 1'b0);       // kind-one failure, substep kept
        send_attempt(1'b1, 1'b1, 1'b0);       // success with kind-one keeps the count
        send_attempt(1'b1, 1'b0, 1'b0);       // clears the kind-one count
        repeat (7) send_attempt(1'b0, 1'b0, 1'b0);   // halve down to one tick
        send_attempt(1'b0, 1'b0, 1'b0);       // one-tick failure: last try
        send_attempt(1'b1, 1'b0, 1'b0);       // recovered
        send_attempt(1'b0, 1'b1, 1'b0);       // kind-one failure off the grid
        send_attempt(1'b1, 1'b0, 1'b0);
        send_attempt(1'b1, 1'b1, 1'b0);
        drain();

        // random phases across register settings, extremes first
        for (phase = 0; phase < PHASES; phase++)
        begin
            total = CFG_TOTAL_BITS'($urandom_range(100_000, 16_777_215));
            case (phase)
                0:
                begin
                    tps    = 16'd1;
                    stride = 16'hFFFF;
                    total  = '1;
                end
                1:
                begin
                    tps    = 16'hFFFF;
                    stride = 16'd1;
                end
                2:
                begin
                    // zero grid and stride behave as one
                    tps    = '0;
                    stride = '0;
                end
                3:
                begin
                    tps    = 16'd3;
                    stride = 16'd2;
                end
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       tps = 16'($urandom_range(2, 40));
                        1:       tps = 16'($urandom_range(41, 2000));
                        default: tps = 16'($urandom_range(1, 65535));
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        stride = 16'($urandom_range(1, 65535));
                    else
                        stride = 16'($urandom_range(1, 6));
                end
            endcase
            program_regs(tps, stride, total);
            calm     = (phase == 3) || ($urandom_range(0, 4) == 0);
            fail_pct = $urandom_range(5, 60);
            repeat (ITEMS_PER_PHASE) send_random_attempt();
            drain();
        end
        calm = 1'b0;

        // a finished run never restarts, so the seed picks how it ends
        end_kind = $urandom_range(0, 4);
        case (end_kind)
            0:
            begin
                // completion: get onto the grid, freeze the next step
                while (board.st.grid_phase != 0)
                    send_attempt(1'b1, 1'b0, 1'b0);
                drain();
                write_reg(CFG_TOTAL_STEPS, CFG_DATA_BITS'(board.st.step_count));
                cfg_valid <= 1'b0;
                // failure and abort request are both ignored on the frozen step
                send_attempt(1'b0, 1'b1, 1'b1);
                while (!board.st.done_flag)
                    send_attempt(1'b1, 1'b0, 1'b0);
            end
            1:
            begin
                // step count already past the total when the word arrives
                if ($urandom_range(0, 1) == 0 || board.st.step_count == 0)
                    total = '0;
                else
                    total = CFG_TOTAL_BITS'(board.st.step_count - 1'b1);
                write_reg(CFG_TOTAL_STEPS, CFG_DATA_BITS'(total));
                cfg_valid <= 1'b0;
                send_attempt(1'($urandom), 1'($urandom), 1'b0);
            end
            2:
            begin
                // two kind-one failures in a row
                if (board.st.last_try_flag)
                    send_attempt(1'b1, 1'b0, 1'b0);
                send_attempt(1'b0, 1'b1, 1'b0);
                send_attempt(1'b0, 1'b1, 1'b0);
            end
            3:
            begin
                send_attempt(1'($urandom), 1'($urandom), 1'b1);   // external abort
            end
            default:
            begin
                // halve to one tick, last try, then fail once more
                while (!board.st.last_try_flag && !board.st.done_flag)
                    send_attempt(1'b0, 1'b0, 1'b0);
                send_attempt(1'b0, 1'b0, 1'b0);
            end
        endcase

        // after the finish every word is a no-change
        for (i = 0; i < 8; i++)
            send_attempt(i[2], i[1], i[0]);
        drain();

        if (board.mismatches == 0 && board.expected_reports.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // hard stop in case a handshake never completes
    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
